// File: rtl/ncp_pkg.sv
// Package for the nearest-circle picker: sizes, register codes and controller links.
`default_nettype none

package ncp_pkg;

  // Fixed-point format of coordinates and radii.
  localparam int INT_BITS  = 12;
  localparam int FRAC_BITS = 4;
  localparam int COORD_W   = INT_BITS + FRAC_BITS;

  // Squared component, radicand, root and cost widths.
  localparam int SQ_W    = 2 * COORD_W;
  localparam int RAD_W   = SQ_W + 1;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int RADP_W  = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int ERR_W   = ROOT_W;
  localparam int COST_W  = ERR_W + 2;
  localparam int SCNT_W  = $clog2(ROOT_W);

  // Reference points and configuration port.
  localparam int NUM_POINTS = 3;
  localparam int PT_IDX_W   = $clog2(NUM_POINTS);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P1_X = 3'd0,
    REG_P1_Y = 3'd1,
    REG_P2_X = 3'd2,
    REG_P2_Y = 3'd3,
    REG_P3_X = 3'd4,
    REG_P3_Y = 3'd5
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic diff;
    logic mul_x;
    logic mul_y;
    logic sqrt_init;
    logic sqrt_step;
    logic accum;
    logic decide;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_last;
    logic pt_last;
    logic item_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/ncp_if.sv
// Channel interfaces of the nearest-circle picker: candidate input, result and configuration.
`default_nettype none

interface ncp_in_if;
  logic                        valid;
  logic                        ready;
  logic [ncp_pkg::COORD_W-1:0] circle_x;
  logic [ncp_pkg::COORD_W-1:0] circle_y;
  logic [ncp_pkg::COORD_W-1:0] circle_r;
  logic                        last_circle;

  modport source (output valid, circle_x, circle_y, circle_r, last_circle, input ready);
  modport sink   (input valid, circle_x, circle_y, circle_r, last_circle, output ready);
endinterface

interface ncp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ncp_pkg::INT_BITS-1:0] best_centre_x;
  logic [ncp_pkg::INT_BITS-1:0] best_centre_y;
  logic [ncp_pkg::INT_BITS-1:0] best_radius;

  modport source (output valid, best_centre_x, best_centre_y, best_radius, input ready);
  modport sink   (input valid, best_centre_x, best_centre_y, best_radius, output ready);
endinterface

interface ncp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ncp_pkg::CFG_IDX_W-1:0] index;
  logic [ncp_pkg::COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ncp_ctrl.sv
// Controller state machine that sequences the cost computation for one candidate.
`default_nettype none

module ncp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ncp_pkg::dp_sts_t sts,
  output ncp_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MULX,
    S_MULY,
    S_SINIT,
    S_SSTEP,
    S_ACCUM,
    S_DECIDE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_SINIT;
      end
      S_SINIT: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = sts.pt_last ? S_DECIDE : S_DIFF;
      end
      S_DECIDE: begin
        // A final candidate waits until the result register is free.
        if (!sts.item_last || sts.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ncp_dp.sv
// Datapath: reference point registers, shared multiplier, iterative square root, cost and keep logic.
`default_nettype none

module ncp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration writes.
  input  wire logic                          cfg_we,
  input  wire logic [ncp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ncp_pkg::COORD_W-1:0]   cfg_data,
  // Candidate payload.
  input  wire logic [ncp_pkg::COORD_W-1:0]   in_x,
  input  wire logic [ncp_pkg::COORD_W-1:0]   in_y,
  input  wire logic [ncp_pkg::COORD_W-1:0]   in_r,
  input  wire logic                          in_last,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ncp_pkg::INT_BITS-1:0]       out_x,
  output logic [ncp_pkg::INT_BITS-1:0]       out_y,
  output logic [ncp_pkg::INT_BITS-1:0]       out_r,
  // Controller link.
  input  wire ncp_pkg::dp_cmd_t              cmd,
  output ncp_pkg::dp_sts_t                   sts
);

  localparam int CW = ncp_pkg::COORD_W;

  // Reference points.
  logic [CW-1:0] px_r [ncp_pkg::NUM_POINTS];
  logic [CW-1:0] py_r [ncp_pkg::NUM_POINTS];

  // Current candidate.
  logic [CW-1:0] cx_r, cy_r, cr_r;
  logic          last_r;
  logic [ncp_pkg::PT_IDX_W-1:0] pt_r;

  // Distance computation.
  logic [CW-1:0]                  dx_r, dy_r;
  logic [ncp_pkg::SQ_W-1:0]       sqx_r, sqy_r;
  logic [ncp_pkg::RADP_W-1:0]     rad_r;
  logic [ncp_pkg::REM_W-1:0]      rem_r;
  logic [ncp_pkg::ROOT_W-1:0]     root_r;
  logic [ncp_pkg::SCNT_W-1:0]     scnt_r;
  logic [ncp_pkg::COST_W-1:0]     acc_r;

  // Kept circle.
  logic [ncp_pkg::COST_W-1:0] lowest_r;
  logic [CW-1:0]              kept_x_r, kept_y_r, kept_r_r;
  logic                       have_r;

  // Result register.
  logic                         out_valid_r;
  logic [ncp_pkg::INT_BITS-1:0] out_x_r, out_y_r, out_r_r;

  // Combinational helpers.
  logic [CW-1:0]                px_sel, py_sel;
  logic [CW-1:0]                mul_op;
  logic [ncp_pkg::SQ_W-1:0]     prod;
  logic [ncp_pkg::RAD_W-1:0]    rad_sum;
  logic [ncp_pkg::REM_W-1:0]    rem_sh, trial;
  logic [ncp_pkg::ERR_W-1:0]    cr_ext, err;
  logic                         take;
  logic [CW-1:0]                kx_new, ky_new, kr_new;

  assign px_sel = px_r[pt_r];
  assign py_sel = py_r[pt_r];

  // One multiplier, shared between the two squared components.
  assign mul_op  = cmd.mul_y ? dy_r : dx_r;
  assign prod    = ncp_pkg::SQ_W'(mul_op) * ncp_pkg::SQ_W'(mul_op);
  assign rad_sum = ncp_pkg::RAD_W'(sqx_r) + ncp_pkg::RAD_W'(sqy_r);

  // One restoring square-root step: bring down two radicand bits and try a one.
  assign rem_sh = {rem_r[ncp_pkg::REM_W-3:0], rad_r[ncp_pkg::RADP_W-1 -: 2]};
  assign trial  = ncp_pkg::REM_W'({root_r, 2'b01});

  // Absolute distance error against the radius.
  assign cr_ext = ncp_pkg::ERR_W'(cr_r);
  assign err    = (root_r >= cr_ext) ? (root_r - cr_ext) : (cr_ext - root_r);

  // Strictly smaller cost replaces the kept circle; the first candidate always does.
  assign take   = !have_r || (acc_r < lowest_r);
  assign kx_new = take ? cx_r : kept_x_r;
  assign ky_new = take ? cy_r : kept_y_r;
  assign kr_new = take ? cr_r : kept_r_r;

  // Status to the controller.
  assign sts.sqrt_last = (scnt_r == '0);
  assign sts.pt_last   = (pt_r == ncp_pkg::PT_IDX_W'(ncp_pkg::NUM_POINTS - 1));
  assign sts.item_last = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_r     = out_r_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ncp_pkg::NUM_POINTS; i++) begin
        px_r[i] <= '0;
        py_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        ncp_pkg::REG_P1_X: px_r[0] <= cfg_data;
        ncp_pkg::REG_P1_Y: py_r[0] <= cfg_data;
        ncp_pkg::REG_P2_X: px_r[1] <= cfg_data;
        ncp_pkg::REG_P2_Y: py_r[1] <= cfg_data;
        ncp_pkg::REG_P3_X: px_r[2] <= cfg_data;
        ncp_pkg::REG_P3_Y: py_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Candidate capture and per-point arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= in_x;
      cy_r   <= in_y;
      cr_r   <= in_r;
      last_r <= in_last;
    end
    if (cmd.diff) begin
      dx_r <= (cx_r >= px_sel) ? (cx_r - px_sel) : (px_sel - cx_r);
      dy_r <= (cy_r >= py_sel) ? (cy_r - py_sel) : (py_sel - cy_r);
    end
    if (cmd.mul_x) begin
      sqx_r <= prod;
    end
    if (cmd.mul_y) begin
      sqy_r <= prod;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= ncp_pkg::RADP_W'(rad_sum);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[ncp_pkg::RADP_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ncp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ncp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Point index, step counter and cost accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r   <= '0;
      scnt_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.load) begin
        pt_r  <= '0;
        acc_r <= '0;
      end else if (cmd.accum) begin
        pt_r  <= pt_r + 1'b1;
        acc_r <= acc_r + ncp_pkg::COST_W'(err);
      end
      if (cmd.sqrt_init) begin
        scnt_r <= ncp_pkg::SCNT_W'(ncp_pkg::ROOT_W - 1);
      end else if (cmd.sqrt_step && (scnt_r != '0)) begin
        scnt_r <= scnt_r - 1'b1;
      end
    end
  end

  // Kept circle and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      lowest_r    <= '0;
      kept_x_r    <= '0;
      kept_y_r    <= '0;
      kept_r_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.decide && last_r) begin
        // Emit the kept circle in integer pixels and start a new list.
        out_x_r     <= kx_new[CW-1:ncp_pkg::FRAC_BITS];
        out_y_r     <= ky_new[CW-1:ncp_pkg::FRAC_BITS];
        out_r_r     <= kr_new[CW-1:ncp_pkg::FRAC_BITS];
        out_valid_r <= 1'b1;
        have_r      <= 1'b0;
        lowest_r    <= '0;
        kept_x_r    <= '0;
        kept_y_r    <= '0;
        kept_r_r    <= '0;
      end else begin
        if (out_valid_r && out_ready) begin
          out_valid_r <= 1'b0;
        end
        if (cmd.decide && take) begin
          have_r   <= 1'b1;
          lowest_r <= acc_r;
          kept_x_r <= cx_r;
          kept_y_r <= cy_r;
          kept_r_r <= cr_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nearest_circle_by_three_points_top.sv
// Top level of the nearest-circle picker: channel wiring of controller and datapath.
//
//   Channel  Direction  Payload                                      Transfer
//   in_ch    sink       circle_x, circle_y, circle_r, last_circle    valid && ready
//   out_ch   source     best_centre_x, best_centre_y, best_radius    valid && ready
//   cfg_ch   sink       index (0..5 = point1_x .. point3_y), data    valid && ready
//
// Each candidate is accepted, then for each reference point the block forms the
// difference, makes two squarings on the one multiplier, loads the radicand,
// runs 17 square-root steps and accumulates, then compares and keeps.
// The 17-step square-root loop thus runs three times per candidate.
// Reset (rst_n low, synchronous) clears the points to zero and forgets any kept circle.
// A final candidate waits in its compare step while an earlier result is not yet taken.
`default_nettype none

module nearest_circle_by_three_points_top (
  input wire logic  clk,
  input wire logic  rst_n,
  ncp_in_if.sink    in_ch,
  ncp_out_if.source out_ch,
  ncp_cfg_if.sink   cfg_ch
);

  ncp_pkg::dp_cmd_t cmd;
  ncp_pkg::dp_sts_t sts;

  // Registers accept a write in every cycle.
  assign cfg_ch.ready = 1'b1;

  ncp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ncp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_x      (in_ch.circle_x),
    .in_y      (in_ch.circle_y),
    .in_r      (in_ch.circle_r),
    .in_last   (in_ch.last_circle),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.best_centre_x),
    .out_y     (out_ch.best_centre_y),
    .out_r     (out_ch.best_radius),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
